FILE: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UNSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("unss assertion failed");

// Next-cycle implication.
`define UNSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("unss assertion failed");

`endif

FILE: hdl/unss_pkg.sv
`default_nettype none

package unss_pkg;

  localparam int PAYLOAD_MAX = 256;
  localparam int LINE_MAX    = 160;
  localparam int LINE_MIN    = 7;

  localparam int POS_W  = $clog2(PAYLOAD_MAX);
  localparam int LCNT_W = $clog2(LINE_MAX);

  typedef logic [7:0]  octet_t;
  typedef logic [15:0] len_t;

  localparam octet_t SYNC_1    = 8'hB5;
  localparam octet_t SYNC_2    = 8'h62;
  localparam octet_t CH_CR     = 8'h0D;
  localparam octet_t CH_LF     = 8'h0A;
  localparam octet_t CH_DOLLAR = 8'h24;

  typedef enum logic [2:0] {
    FEV_NONE    = 3'd0,
    FEV_OK      = 3'd1,
    FEV_TOO_BIG = 3'd2,
    FEV_CHK_A   = 3'd3,
    FEV_CHK_B   = 3'd4
  } fev_t;

  typedef enum logic [2:0] {
    LEV_NONE     = 3'd0,
    LEV_STORED   = 3'd1,
    LEV_ACCEPTED = 3'd2,
    LEV_OVERFLOW = 3'd3,
    LEV_REJECTED = 3'd4
  } lev_t;

  typedef struct packed {
    fev_t   event_code;
    octet_t cls;
    octet_t ident;
    len_t   length;
    logic   pvalid;
    octet_t pidx;
  } frm_res_t;

  typedef struct packed {
    lev_t   event_code;
    octet_t lidx;
    octet_t llen;
  } line_res_t;

endpackage

`default_nettype wire

FILE: hdl/unss_ifs.sv
`default_nettype none

interface unss_in_if;
  logic              valid;
  logic              ready;
  unss_pkg::octet_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface unss_out_if;
  logic              valid;
  logic              ready;
  unss_pkg::octet_t  data_byte;
  logic [2:0]        frame_event;
  unss_pkg::octet_t  frame_class;
  unss_pkg::octet_t  frame_ident;
  unss_pkg::len_t    frame_length;
  logic              payload_valid;
  unss_pkg::octet_t  payload_index;
  logic [2:0]        line_event;
  unss_pkg::octet_t  line_index;
  unss_pkg::octet_t  line_length;

  modport source (output valid, output data_byte, output frame_event, output frame_class,
                  output frame_ident, output frame_length, output payload_valid,
                  output payload_index, output line_event, output line_index,
                  output line_length, input ready);
  modport sink   (input valid, input data_byte, input frame_event, input frame_class,
                  input frame_ident, input frame_length, input payload_valid,
                  input payload_index, input line_event, input line_index,
                  input line_length, output ready);
endinterface

`default_nettype wire

FILE: hdl/unss_deframer.sv
`default_nettype none

module unss_deframer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire unss_pkg::octet_t   rx,
  output unss_pkg::frm_res_t      res
);
  import unss_pkg::*;

  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_IDENT   = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHECK_A = 9'b010000000,
    PH_CHECK_B = 9'b100000000
  } phase_t;

  phase_t          ph_r, ph_nxt;
  octet_t          cls_r, cls_nxt;
  octet_t          ident_r, ident_nxt;
  len_t            len_r, len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  octet_t          sa_r, sa_nxt;
  octet_t          sb_r, sb_nxt;

  octet_t          add_a, add_b;
  len_t            len_full;
  logic [POS_W:0]  pos_inc;

  assign add_a    = sa_r + rx;
  assign add_b    = sb_r + add_a;
  assign len_full = {rx, len_r[7:0]};
  assign pos_inc  = {1'b0, pos_r} + (POS_W+1)'(1);

  always_comb begin
    ph_nxt         = ph_r;
    cls_nxt        = cls_r;
    ident_nxt      = ident_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    res.event_code = FEV_NONE;
    res.pvalid     = 1'b0;
    res.pidx       = '0;
    unique case (ph_r)
      PH_SYNC1: begin
        if (rx == SYNC_1) ph_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx == SYNC_2) begin
          ph_nxt = PH_CLASS;
          sa_nxt = '0;
          sb_nxt = '0;
        end else begin
          ph_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        cls_nxt = rx;
        sa_nxt  = add_a;
        sb_nxt  = add_b;
        ph_nxt  = PH_IDENT;
      end
      PH_IDENT: begin
        ident_nxt = rx;
        sa_nxt    = add_a;
        sb_nxt    = add_b;
        ph_nxt    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = {8'h00, rx};
        sa_nxt  = add_a;
        sb_nxt  = add_b;
        ph_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt = len_full;
        sa_nxt  = add_a;
        sb_nxt  = add_b;
        if (len_full >= len_t'(PAYLOAD_MAX)) begin
          res.event_code = FEV_TOO_BIG;
          ph_nxt         = PH_SYNC1;
        end else begin
          pos_nxt = '0;
          ph_nxt  = (len_full == '0) ? PH_CHECK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.pvalid = 1'b1;
        res.pidx   = 8'(pos_r);
        sa_nxt     = add_a;
        sb_nxt     = add_b;
        pos_nxt    = pos_inc[POS_W-1:0];
        if (16'(pos_inc) >= len_r) ph_nxt = PH_CHECK_A;
      end
      PH_CHECK_A: begin
        if (rx == sa_r) begin
          ph_nxt = PH_CHECK_B;
        end else begin
          res.event_code = FEV_CHK_A;
          ph_nxt         = PH_SYNC1;
        end
      end
      PH_CHECK_B: begin
        res.event_code = (rx == sb_r) ? FEV_OK : FEV_CHK_B;
        ph_nxt         = PH_SYNC1;
      end
      default: ph_nxt = PH_SYNC1;
    endcase
    res.cls    = cls_nxt;
    res.ident  = ident_nxt;
    res.length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_SYNC1;
      cls_r   <= '0;
      ident_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
    end else if (en) begin
      ph_r    <= ph_nxt;
      cls_r   <= cls_nxt;
      ident_r <= ident_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/unss_line.sv
`default_nettype none

module unss_line (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire unss_pkg::octet_t   rx,
  output unss_pkg::line_res_t     res
);
  import unss_pkg::*;

  logic [LCNT_W-1:0] cnt_r, cnt_nxt;
  logic              dollar_r, dollar_nxt;

  always_comb begin
    cnt_nxt        = cnt_r;
    dollar_nxt     = dollar_r;
    res.event_code = LEV_NONE;
    res.lidx       = '0;
    res.llen       = '0;
    if (rx == CH_CR) begin
      // carriage return: line untouched
    end else if (rx == CH_LF) begin
      if (cnt_r >= LCNT_W'(LINE_MIN) && dollar_r) begin
        res.event_code = LEV_ACCEPTED;
        res.llen       = 8'(cnt_r);
      end else begin
        res.event_code = LEV_REJECTED;
      end
      cnt_nxt    = '0;
      dollar_nxt = 1'b0;
    end else if (cnt_r < LCNT_W'(LINE_MAX - 1)) begin
      if (cnt_r == '0) dollar_nxt = (rx == CH_DOLLAR);
      res.event_code = LEV_STORED;
      res.lidx       = 8'(cnt_r);
      cnt_nxt        = cnt_r + LCNT_W'(1);
    end else begin
      res.event_code = LEV_OVERFLOW;
      cnt_nxt        = '0;
      dollar_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      dollar_r <= 1'b0;
    end else if (en) begin
      cnt_r    <= cnt_nxt;
      dollar_r <= dollar_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ubx_nmea_stream_splitter_core.sv
// The result beat is registered and appears in the cycle after its input byte is accepted.
// Throughput: one beat per cycle; a new byte is taken whenever the result
// register is empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): deframer back to hunting for sync, sums,
// frame fields and line count cleared, result register emptied.
`default_nettype none

`include "assert_macros.svh"

module ubx_nmea_stream_splitter_core (
  input wire logic   clk,
  input wire logic   rst_n,
  unss_in_if.sink    in_bus,
  unss_out_if.source out_bus
);
  import unss_pkg::*;

  logic      accept;
  frm_res_t  frm;
  line_res_t lin;

  logic      ov_r;
  octet_t    data_r;
  frm_res_t  frm_r;
  line_res_t lin_r;

  assign in_bus.ready = !ov_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  unss_deframer u_deframer (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .rx    (in_bus.rx_byte),
    .res   (frm)
  );

  unss_line u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .rx    (in_bus.rx_byte),
    .res   (lin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (accept) begin
      ov_r <= 1'b1;
    end else if (out_bus.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_bus.rx_byte;
      frm_r  <= frm;
      lin_r  <= lin;
    end
  end

  assign out_bus.valid         = ov_r;
  assign out_bus.data_byte     = data_r;
  assign out_bus.frame_event   = frm_r.event_code;
  assign out_bus.frame_class   = frm_r.cls;
  assign out_bus.frame_ident   = frm_r.ident;
  assign out_bus.frame_length  = frm_r.length;
  assign out_bus.payload_valid = frm_r.pvalid;
  assign out_bus.payload_index = frm_r.pidx;
  assign out_bus.line_event    = lin_r.event_code;
  assign out_bus.line_index    = lin_r.lidx;
  assign out_bus.line_length   = lin_r.llen;

  `UNSS_ASSERT_IMP(a_pay_no_fev, ov_r && frm_r.pvalid, frm_r.event_code == FEV_NONE)
  `UNSS_ASSERT_IMP(a_acc_len, ov_r && lin_r.event_code == LEV_ACCEPTED, lin_r.llen >= 8'(LINE_MIN))
  `UNSS_ASSERT_IMP(a_stall_hold, ov_r && !out_bus.ready, !in_bus.ready)
  `UNSS_ASSERT_NXT(a_accept_fills, accept, ov_r)

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import unss_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 1200;
  localparam int CALM_TAIL    = 150;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CLASS, PH_IDENT, PH_LEN_LO, PH_LEN_HI,
    PH_BODY, PH_CK_A, PH_CK_B
  } deframe_ph_t;

  typedef enum {FLAW_NONE, FLAW_CK_A, FLAW_CK_B, FLAW_CUT} frame_flaw_t;

  typedef struct packed {
    octet_t data;
    fev_t   fev;
    octet_t cls;
    octet_t ident;
    len_t   len;
    logic   pvalid;
    octet_t pidx;
    lev_t   lev;
    octet_t lidx;
    octet_t llen;
  } split_beat_t;

  typedef struct {
    octet_t b;
    bit     drain;
  } rx_beat_t;

  logic clk;
  logic rst_n;

  unss_in_if  in_bus ();
  unss_out_if out_bus ();

  ubx_nmea_stream_splitter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // deframer and line collector mirror
  deframe_ph_t ph          = PH_HUNT1;
  octet_t      cls_q       = '0;
  octet_t      id_q        = '0;
  len_t        len_q       = '0;
  int          body_pos    = 0;
  octet_t      ck_a        = '0;
  octet_t      ck_b        = '0;
  int          line_cnt    = 0;
  bit          line_dollar = 1'b0;

  rx_beat_t    rx_pending[$];
  split_beat_t expected_beats[$];

  int  cycle_count    = 0;
  int  accepted_count = 0;
  int  total_beats    = 0;
  int  fail_count     = 0;
  bit  in_taken       = 1'b0;
  int  send_gap       = 0;
  int  send_idle_pct  = 15;
  int  stall_left     = 0;
  int  recv_idle_pct  = 15;

  int  frames_ok, frame_faults, lines_ok, lines_dropped, payload_beats;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fletcher_add(octet_t b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endfunction

  function automatic split_beat_t predict_beat(octet_t c);
    split_beat_t r;
    r      = '0;
    r.data = c;
    r.fev  = FEV_NONE;
    r.lev  = LEV_NONE;
    case (ph)
      PH_HUNT1: if (c == SYNC_1) ph = PH_HUNT2;
      PH_HUNT2: begin
        if (c == SYNC_2) begin
          ph   = PH_CLASS;
          ck_a = '0;
          ck_b = '0;
        end else begin
          ph = PH_HUNT1;
        end
      end
      PH_CLASS: begin
        cls_q = c;
        fletcher_add(c);
        ph = PH_IDENT;
      end
      PH_IDENT: begin
        id_q = c;
        fletcher_add(c);
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_q = {8'h00, c};
        fletcher_add(c);
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_q[15:8] = c;
        fletcher_add(c);
        if (len_q >= PAYLOAD_MAX) begin
          r.fev = FEV_TOO_BIG;
          ph    = PH_HUNT1;
        end else begin
          body_pos = 0;
          ph       = (len_q == 0) ? PH_CK_A : PH_BODY;
        end
      end
      PH_BODY: begin
        r.pvalid = 1'b1;
        r.pidx   = body_pos[7:0];
        fletcher_add(c);
        body_pos++;
        if (body_pos >= len_q) ph = PH_CK_A;
      end
      PH_CK_A: begin
        if (c == ck_a) begin
          ph = PH_CK_B;
        end else begin
          r.fev = FEV_CHK_A;
          ph    = PH_HUNT1;
        end
      end
      PH_CK_B: begin
        r.fev = (c == ck_b) ? FEV_OK : FEV_CHK_B;
        ph    = PH_HUNT1;
      end
      default: ph = PH_HUNT1;
    endcase
    r.cls   = cls_q;
    r.ident = id_q;
    r.len   = len_q;

    // carriage return leaves the line untouched
    if (c != CH_CR) begin
      if (c == CH_LF) begin
        if (line_cnt >= LINE_MIN && line_dollar) begin
          r.lev  = LEV_ACCEPTED;
          r.llen = line_cnt[7:0];
        end else begin
          r.lev = LEV_REJECTED;
        end
        line_cnt    = 0;
        line_dollar = 1'b0;
      end else if (line_cnt < LINE_MAX - 1) begin
        if (line_cnt == 0) line_dollar = (c == CH_DOLLAR);
        r.lev  = LEV_STORED;
        r.lidx = line_cnt[7:0];
        line_cnt++;
      end else begin
        r.lev       = LEV_OVERFLOW;
        line_cnt    = 0;
        line_dollar = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_beat(octet_t b, bit drain = 1'b0);
    rx_beat_t nb;
    nb.b     = b;
    nb.drain = drain;
    rx_pending.push_back(nb);
  endtask

  task automatic push_frame(octet_t cl, octet_t id, int len, frame_flaw_t flaw, bit drain);
    octet_t fr[$];
    octet_t a;
    octet_t b;
    int     cut;
    a = '0;
    b = '0;
    fr.push_back(SYNC_1);
    fr.push_back(SYNC_2);
    fr.push_back(cl);
    fr.push_back(id);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    if (len < PAYLOAD_MAX) begin
      for (int i = 0; i < len; i++) fr.push_back(octet_t'($urandom));
      for (int i = 2; i < fr.size(); i++) begin
        a = a + fr[i];
        b = b + a;
      end
      if (flaw == FLAW_CK_A) a = a ^ octet_t'($urandom_range(1, 255));
      if (flaw == FLAW_CK_B) b = b ^ octet_t'($urandom_range(1, 255));
      fr.push_back(a);
      fr.push_back(b);
    end
    cut = fr.size();
    if (flaw == FLAW_CUT) cut = $urandom_range(1, fr.size() - 1);
    for (int i = 0; i < cut; i++) push_beat(fr[i], drain && (i == 0));
  endtask

  task automatic push_line(int n, bit dollar, bit drain);
    push_beat(CH_LF, drain);
    if (dollar) push_beat(CH_DOLLAR);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) push_beat(CH_CR);
      push_beat(octet_t'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 1)) push_beat(CH_CR);
    push_beat(CH_LF);
  endtask

  task automatic build_stimulus();
    int  sel;
    int  len;
    int  r;
    bit  drain_next;
    frame_flaw_t flaw;
    // second sync wrong: the repeated 0xB5 is not taken as a new first sync
    push_beat(SYNC_1);
    push_beat(SYNC_1);
    push_beat(SYNC_2);
    push_frame(8'hFF, 8'h00, 0, FLAW_NONE, 1'b0);
    push_frame(8'h00, 8'hFF, 16'hFFFF, FLAW_NONE, 1'b0);
    push_beat(CH_CR);
    push_beat(CH_LF);
    push_beat(CH_DOLLAR);
    push_beat(8'h41);
    push_beat(CH_LF);

    drain_next = 1'b1;
    while (rx_pending.size() < RANDOM_BEATS) begin
      if (rx_pending.size() > RANDOM_BEATS / 2 && rx_pending.size() < RANDOM_BEATS / 2 + 40)
        drain_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 19) == 0) len = $urandom_range(256, 65535);
        else if ($urandom_range(0, 19) == 0) len = $urandom_range(25, 255);
        else if ($urandom_range(0, 59) == 0) len = 255;
        else len = $urandom_range(0, 24);
        r = $urandom_range(0, 9);
        case (r)
          0:       flaw = FLAW_CK_A;
          1:       flaw = FLAW_CK_B;
          2:       flaw = FLAW_CUT;
          default: flaw = FLAW_NONE;
        endcase
        push_frame(octet_t'($urandom), octet_t'($urandom), len, flaw, drain_next);
      end else if (sel < 80) begin
        if ($urandom_range(0, 39) == 0) len = $urandom_range(156, 170);
        else len = $urandom_range(0, 12);
        push_line(len, $urandom_range(0, 9) != 0, drain_next);
      end else if (sel < 90) begin
        push_beat(SYNC_1, drain_next);
        push_beat(octet_t'($urandom));
      end else begin
        r = $urandom_range(1, 8);
        for (int i = 0; i < r; i++) push_beat(octet_t'($urandom), drain_next && (i == 0));
      end
      drain_next = 1'b0;
    end
  endtask

  always @(posedge clk) begin : sample_edge
    split_beat_t e;
    cycle_count <= cycle_count + 1;
    in_taken    <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      e = predict_beat(in_bus.rx_byte);
      expected_beats.push_back(e);
      accepted_count++;
      if (e.fev == FEV_OK) frames_ok++;
      if (e.fev inside {FEV_TOO_BIG, FEV_CHK_A, FEV_CHK_B}) frame_faults++;
      if (e.lev == LEV_ACCEPTED) lines_ok++;
      if (e.lev == LEV_OVERFLOW) lines_dropped++;
      if (e.pvalid) payload_beats++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no byte outstanding");
        fail_count++;
      end else begin
        e = expected_beats.pop_front();
        check_field("data_byte", e.data, out_bus.data_byte);
        check_field("frame_event", e.fev, out_bus.frame_event);
        check_field("frame_class", e.cls, out_bus.frame_class);
        check_field("frame_ident", e.ident, out_bus.frame_ident);
        check_field("frame_length", e.len, out_bus.frame_length);
        check_field("payload_valid", e.pvalid, out_bus.payload_valid);
        check_field("payload_index", e.pidx, out_bus.payload_index);
        check_field("line_event", e.lev, out_bus.line_event);
        check_field("line_index", e.lidx, out_bus.line_index);
        check_field("line_length", e.llen, out_bus.line_length);
      end
    end
  end

  always @(negedge clk) begin : feed_side
    rx_beat_t nb;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (rx_pending.size() != 0 &&
                   !(rx_pending[0].drain && expected_beats.size() != 0)) begin
        nb = rx_pending.pop_front();
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= nb.b;
        if (rx_pending.size() > CALM_TAIL && $urandom_range(0, 99) < send_idle_pct)
          send_gap = $urandom_range(1, 16);
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 15;
            default: send_idle_pct = 40;
          endcase
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_side
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (rx_pending.size() > CALM_TAIL && $urandom_range(0, 99) < recv_idle_pct)
        stall_left = $urandom_range(1, 16);
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       recv_idle_pct = 0;
          1:       recv_idle_pct = 15;
          default: recv_idle_pct = 40;
        endcase
      end
    end
  end

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    rst_n          = 1'b0;
    frames_ok      = 0;
    frame_faults   = 0;
    lines_ok       = 0;
    lines_dropped  = 0;
    payload_beats  = 0;
    build_stimulus();
    total_beats = rx_pending.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_beats || expected_beats.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("%0d bytes: %0d frames good, %0d frame faults, %0d payload beats",
             total_beats, frames_ok, frame_faults, payload_beats);
    $display("%0d lines accepted, %0d line overflows", lines_ok, lines_dropped);
    if (fail_count == 0) begin
      $display("[ubx_nmea_stream_splitter_core] OK");
    end else begin
      $display("[ubx_nmea_stream_splitter_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("[ubx_nmea_stream_splitter_core] ERROR");
    $finish;
  end

endmodule
